### src/first_fit_heap_allocator_unit_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFA_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FFA_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

### src/ffa_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
package ffa_pkg;
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 64;

  localparam int SZ_W   = 13;
  localparam int OFF_W  = 12;
  localparam int ST_W   = 3;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int ACC_W  = $clog2(HEAP_BYTES + 2 * HEADER_BYTES) + 1;
  localparam int ENT_W  = SZ_W + 1;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPTR  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_RD_I, DP_STEP, DP_LATCH, DP_WR_USED, DP_WR_USED_INC,
    DP_K_COUNT, DP_RD_KM1, DP_WR_UP, DP_WR_REM, DP_WR_FREE, DP_RD_IP1,
    DP_MERGE_A, DP_RD_KP1, DP_WR_DOWN, DP_DEC_CNT, DP_RD_IM1, DP_MERGE_B
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ffa_cmd_t;

  typedef struct packed {
    logic             is_free;
    logic             req_zero;
    logic             walk_end;
    logic             hit;
    logic             rfree;
    logic             exact;
    logic             full;
    logic             up_more;
    logic             down_more;
    logic             has_next;
    logic             has_prev;
    logic [OFF_W-1:0] grant;
  } ffa_stat_t;
endpackage

### src/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### src/ffa_datapath.sv
// Block table, walk pointers, offset accumulator and table update logic.
module ffa_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_command,
  input  logic [ffa_pkg::SZ_W-1:0]    in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]   in_data_offset,
  input  ffa_pkg::ffa_cmd_t           cmd,
  output ffa_pkg::ffa_stat_t          stat
);
  localparam int IW = ffa_pkg::IDX_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int SW = ffa_pkg::SZ_W;
  localparam int AW = ffa_pkg::ACC_W;
  localparam int EW = ffa_pkg::ENT_W;
  localparam logic [SW-1:0] HDR_S = SW'(ffa_pkg::HEADER_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(ffa_pkg::HEADER_BYTES);
  localparam logic [SW-1:0] E0_SZ = SW'(ffa_pkg::HEAP_BYTES - ffa_pkg::HEADER_BYTES);

  logic             cmd_r;
  logic [SW-1:0]    req_r;
  logic [ffa_pkg::OFF_W-1:0] off_r;
  logic [CW-1:0]    i_r, k_r, cnt_r;
  logic [AW-1:0]    acc_r;
  logic [SW-1:0]    cur_sz_r;
  logic             e0_ok_r, rd0_r;

  logic             we;
  logic [IW-1:0]    waddr, raddr;
  logic [EW-1:0]    wdata, rdata, ent;
  logic [SW-1:0]    rsz;
  logic             rfree;
  logic [CW-1:0]    i_p1, i_m1, k_p1, k_m1;

  ffa_ram #(.WIDTH(EW), .DEPTH(ffa_pkg::MAX_BLOCKS)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // entry 0 reads as the reset block until it is first written
  assign ent   = (rd0_r && !e0_ok_r) ? {E0_SZ, 1'b1} : rdata;
  assign rsz   = ent[EW-1:1];
  assign rfree = ent[0];

  assign i_p1 = i_r + CW'(1);
  assign i_m1 = i_r - CW'(1);
  assign k_p1 = k_r + CW'(1);
  assign k_m1 = k_r - CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = i_r[IW-1:0];
    wdata = {cur_sz_r, 1'b1};
    raddr = i_r[IW-1:0];
    unique case (cmd.op)
      ffa_pkg::DP_WR_USED, ffa_pkg::DP_WR_USED_INC: begin
        we    = 1'b1;
        wdata = {req_r, 1'b0};
      end
      ffa_pkg::DP_WR_UP, ffa_pkg::DP_WR_DOWN: begin
        we    = 1'b1;
        waddr = k_r[IW-1:0];
        wdata = ent;
      end
      ffa_pkg::DP_WR_REM: begin
        we    = 1'b1;
        waddr = i_p1[IW-1:0];
        wdata = {cur_sz_r - req_r - HDR_S, 1'b1};
      end
      ffa_pkg::DP_WR_FREE: we = 1'b1;
      ffa_pkg::DP_MERGE_A: begin
        we    = 1'b1;
        wdata = {cur_sz_r + HDR_S + rsz, 1'b1};
      end
      ffa_pkg::DP_MERGE_B: begin
        we    = 1'b1;
        waddr = i_m1[IW-1:0];
        wdata = {rsz + HDR_S + cur_sz_r, 1'b1};
      end
      ffa_pkg::DP_RD_KM1: raddr = k_m1[IW-1:0];
      ffa_pkg::DP_RD_IP1: raddr = i_p1[IW-1:0];
      ffa_pkg::DP_RD_KP1: raddr = k_p1[IW-1:0];
      ffa_pkg::DP_RD_IM1: raddr = i_m1[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CW'(1);
      e0_ok_r <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
    end else begin
      if (we && waddr == '0) begin
        e0_ok_r <= 1'b1;
      end
      unique case (cmd.op)
        ffa_pkg::DP_LOAD:        i_r <= '0;
        ffa_pkg::DP_STEP:        i_r <= i_p1;
        ffa_pkg::DP_WR_USED_INC: cnt_r <= cnt_r + CW'(1);
        ffa_pkg::DP_DEC_CNT:     cnt_r <= cnt_r - CW'(1);
        ffa_pkg::DP_K_COUNT:     k_r <= cnt_r;
        ffa_pkg::DP_WR_UP:       k_r <= k_m1;
        ffa_pkg::DP_WR_DOWN:     k_r <= k_p1;
        ffa_pkg::DP_MERGE_A:     k_r <= i_p1;
        ffa_pkg::DP_MERGE_B:     k_r <= i_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= (raddr == '0);
    unique case (cmd.op)
      ffa_pkg::DP_LOAD: begin
        cmd_r <= in_command;
        req_r <= in_request_bytes;
        off_r <= in_data_offset;
        acc_r <= in_command ? HDR_A : '0;
      end
      ffa_pkg::DP_STEP:    acc_r    <= acc_r + HDR_A + AW'(rsz);
      ffa_pkg::DP_LATCH:   cur_sz_r <= rsz;
      ffa_pkg::DP_MERGE_A: cur_sz_r <= cur_sz_r + HDR_S + rsz;
      default: ;
    endcase
  end

  always_comb begin
    stat.is_free   = cmd_r;
    stat.req_zero  = (req_r == '0);
    stat.walk_end  = (i_r >= cnt_r);
    stat.rfree     = rfree;
    stat.hit       = cmd_r ? (acc_r == AW'(off_r))
                           : (rfree && (rsz == req_r ||
                              {1'b0, rsz} > ({1'b0, req_r} + {1'b0, HDR_S})));
    stat.exact     = (cur_sz_r == req_r);
    stat.full      = (cnt_r >= CW'(ffa_pkg::MAX_BLOCKS));
    stat.up_more   = (k_r > i_p1);
    stat.down_more = (k_p1 < cnt_r);
    stat.has_next  = (i_p1 < cnt_r);
    stat.has_prev  = (i_r != '0);
    stat.grant     = ffa_pkg::OFF_W'(acc_r + HDR_A);
  end
endmodule

### src/ffa_controller.sv
// Sequencer for walk, split, mark and merge, plus the result registers.
module ffa_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ffa_pkg::ffa_stat_t          stat,
  output ffa_pkg::ffa_cmd_t           cmd,
  output logic                        out_valid,
  output logic [ffa_pkg::OFF_W-1:0]   out_granted_offset,
  output logic [ffa_pkg::ST_W-1:0]    out_status
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_WRD, S_WEV, S_ADEC, S_SRD, S_SWR, S_SPLIT, S_SUSE,
    S_FMARK, S_FNX, S_FNXE, S_MSRD, S_MSWR, S_FPV, S_FPVE
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;
  logic   fin, fin_grant;
  logic [ffa_pkg::ST_W-1:0] fin_st;
  logic   out_valid_r;
  logic [ffa_pkg::OFF_W-1:0] out_granted_r;
  logic [ffa_pkg::ST_W-1:0]  out_status_r;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd.op     = ffa_pkg::DP_NOP;
    fin        = 1'b0;
    fin_grant  = 1'b0;
    fin_st     = ffa_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.op    = ffa_pkg::DP_LOAD;
        state_nxt = S_CHK;
      end
      S_CHK: if (!stat.is_free && stat.req_zero) begin
        fin = 1'b1; fin_st = ffa_pkg::ST_ZERO; state_nxt = S_IDLE;
      end else begin
        state_nxt = S_WRD;
      end
      S_WRD: if (stat.walk_end) begin
        fin = 1'b1; state_nxt = S_IDLE;
        fin_st = stat.is_free ? ffa_pkg::ST_BADPTR : ffa_pkg::ST_NOSPACE;
      end else begin
        cmd.op = ffa_pkg::DP_RD_I; state_nxt = S_WEV;
      end
      S_WEV: if (stat.hit) begin
        cmd.op = ffa_pkg::DP_LATCH;
        if (!stat.is_free) begin
          state_nxt = S_ADEC;
        end else if (stat.rfree) begin
          fin = 1'b1; fin_st = ffa_pkg::ST_BADPTR; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FMARK;
        end
      end else begin
        cmd.op = ffa_pkg::DP_STEP; state_nxt = S_WRD;
      end
      S_ADEC: if (stat.exact) begin
        cmd.op = ffa_pkg::DP_WR_USED;
        fin = 1'b1; fin_grant = 1'b1; state_nxt = S_IDLE;
      end else if (stat.full) begin
        fin = 1'b1; fin_st = ffa_pkg::ST_FULL; state_nxt = S_IDLE;
      end else begin
        cmd.op = ffa_pkg::DP_K_COUNT; state_nxt = S_SRD;
      end
      S_SRD: if (stat.up_more) begin
        cmd.op = ffa_pkg::DP_RD_KM1; state_nxt = S_SWR;
      end else begin
        state_nxt = S_SPLIT;
      end
      S_SWR: begin
        cmd.op = ffa_pkg::DP_WR_UP; state_nxt = S_SRD;
      end
      S_SPLIT: begin
        cmd.op = ffa_pkg::DP_WR_REM; state_nxt = S_SUSE;
      end
      S_SUSE: begin
        cmd.op = ffa_pkg::DP_WR_USED_INC;
        fin = 1'b1; fin_grant = 1'b1; state_nxt = S_IDLE;
      end
      S_FMARK: begin
        cmd.op = ffa_pkg::DP_WR_FREE; state_nxt = S_FNX;
      end
      S_FNX: if (stat.has_next) begin
        cmd.op = ffa_pkg::DP_RD_IP1; state_nxt = S_FNXE;
      end else begin
        state_nxt = S_FPV;
      end
      S_FNXE: if (stat.rfree) begin
        cmd.op = ffa_pkg::DP_MERGE_A; second_nxt = 1'b0; state_nxt = S_MSRD;
      end else begin
        state_nxt = S_FPV;
      end
      S_MSRD: if (stat.down_more) begin
        cmd.op = ffa_pkg::DP_RD_KP1; state_nxt = S_MSWR;
      end else begin
        cmd.op = ffa_pkg::DP_DEC_CNT;
        if (second_r) begin
          fin = 1'b1; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FPV;
        end
      end
      S_MSWR: begin
        cmd.op = ffa_pkg::DP_WR_DOWN; state_nxt = S_MSRD;
      end
      S_FPV: if (stat.has_prev) begin
        cmd.op = ffa_pkg::DP_RD_IM1; state_nxt = S_FPVE;
      end else begin
        fin = 1'b1; state_nxt = S_IDLE;
      end
      S_FPVE: if (stat.rfree) begin
        cmd.op = ffa_pkg::DP_MERGE_B; second_nxt = 1'b1; state_nxt = S_MSRD;
      end else begin
        fin = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= fin;
    end
    if (fin) begin
      out_status_r  <= fin_st;
      out_granted_r <= fin_grant ? stat.grant : '0;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_granted_r;
endmodule

### src/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: controller plus block-table datapath.
//
// A heap of 4096 bytes is kept as up to 64 blocks in address order, each a
// 16-byte header and a data area, held in a 64-entry table RAM (size and free
// mark per word). A word is accepted when start is high and busy is low; busy
// stays high until the result strobe. The result (granted offset, status)
// appears for exactly one cycle with out_valid high and must be taken then:
// the receiver cannot stall. Every table access has a state that sets the RAM
// read address and a state that uses the registered read data. An item runs
// the first-fit or offset walk, then for an alloc that is not an exact fit a
// split that shifts later entries up, or for a free up to two merges that
// shift later entries down, one table entry at a time in each loop.
// No clearing pass after reset: entry 0 reads as the whole free heap until it
// is first written, and the block count bounds every other read.
module first_fit_heap_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [ffa_pkg::SZ_W-1:0]    in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]   in_data_offset,
  output logic                        out_valid,
  output logic [ffa_pkg::OFF_W-1:0]   out_granted_offset,
  output logic [ffa_pkg::ST_W-1:0]    out_status
);
  ffa_pkg::ffa_cmd_t  cmd;
  ffa_pkg::ffa_stat_t stat;

  ffa_controller u_ctl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd),
    .out_valid(out_valid), .out_granted_offset(out_granted_offset),
    .out_status(out_status)
  );

  ffa_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_data_offset(in_data_offset),
    .cmd(cmd), .stat(stat)
  );
endmodule

### src/ffa_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_heap_allocator_unit_macros.svh"

module ffa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ffa_pkg::OFF_W-1:0]   out_granted_offset,
  input logic [ffa_pkg::ST_W-1:0]    out_status
);
  `FFA_AST_IMP(a_status_code, out_valid, out_status <= ffa_pkg::ST_FULL)
  `FFA_AST_IMP(a_fail_zero, out_valid && out_status != ffa_pkg::ST_OK, out_granted_offset == '0)
  `FFA_AST_NXT(a_accept_busy, start && !busy, busy)
  `FFA_AST_IMP(a_done_idle, out_valid, !busy)
  `FFA_AST_NXT(a_one_strobe, out_valid, !out_valid)
endmodule

bind first_fit_heap_allocator_unit ffa_checker u_ffa_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_granted_offset(out_granted_offset), .out_status(out_status)
);

### sim/first_fit_heap_allocator_unit_test.sv
// Self-checking testbench for the first-fit heap allocator: directed and random alloc/free words.
module first_fit_heap_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam int   IDLE_LIMIT = 5000;  // cycles with no accepted word or result

  // Block-table shadow plus a queue of expected (offset, status) pairs.
  class heap_scoreboard;
    int unsigned blk_size[ffa_pkg::MAX_BLOCKS];
    bit          blk_free[ffa_pkg::MAX_BLOCKS];
    int unsigned blk_cnt;
    logic [ffa_pkg::OFF_W-1:0] exp_offset_q[$];
    logic [ffa_pkg::ST_W-1:0]  exp_status_q[$];
    int errors;
    int n_results;
    int n_by_status[5];

    function new();
      blk_cnt = 1;
      blk_size[0] = ffa_pkg::HEAP_BYTES - ffa_pkg::HEADER_BYTES;
      blk_free[0] = 1'b1;
    endfunction

    // fold entry idx+1 into entry idx
    function void fold_next(int unsigned idx);
      if (idx + 1 >= blk_cnt) return;
      blk_size[idx] += ffa_pkg::HEADER_BYTES + blk_size[idx + 1];
      for (int unsigned k = idx + 1; k + 1 < blk_cnt; k++) begin
        blk_size[k] = blk_size[k + 1];
        blk_free[k] = blk_free[k + 1];
      end
      blk_cnt--;
      blk_size[blk_cnt] = 0;
      blk_free[blk_cnt] = 1'b0;
    endfunction

    function logic [ffa_pkg::ST_W-1:0] alloc_bytes(int unsigned req,
                                                   output int unsigned grant);
      int unsigned i;
      int unsigned hdr;
      hdr = 0;
      grant = 0;
      if (req == 0) return ffa_pkg::ST_ZERO;
      for (i = 0; i < blk_cnt; i++) begin
        if (blk_free[i] && (blk_size[i] == req ||
            blk_size[i] > req + ffa_pkg::HEADER_BYTES)) break;
        hdr += ffa_pkg::HEADER_BYTES + blk_size[i];
      end
      if (i >= blk_cnt) return ffa_pkg::ST_NOSPACE;
      if (blk_size[i] != req) begin
        if (blk_cnt >= ffa_pkg::MAX_BLOCKS) return ffa_pkg::ST_FULL;
        for (int unsigned k = blk_cnt; k > i + 1; k--) begin
          blk_size[k] = blk_size[k - 1];
          blk_free[k] = blk_free[k - 1];
        end
        blk_size[i + 1] = blk_size[i] - req - ffa_pkg::HEADER_BYTES;
        blk_free[i + 1] = 1'b1;
        blk_size[i] = req;
        blk_cnt++;
      end
      blk_free[i] = 1'b0;
      grant = hdr + ffa_pkg::HEADER_BYTES;
      return ffa_pkg::ST_OK;
    endfunction

    function logic [ffa_pkg::ST_W-1:0] free_block(int unsigned off);
      int unsigned i;
      int unsigned data;
      data = ffa_pkg::HEADER_BYTES;
      for (i = 0; i < blk_cnt; i++) begin
        if (data == off) break;
        data += ffa_pkg::HEADER_BYTES + blk_size[i];
      end
      if (i >= blk_cnt || blk_free[i]) return ffa_pkg::ST_BADPTR;
      blk_free[i] = 1'b1;
      if (i + 1 < blk_cnt && blk_free[i + 1]) fold_next(i);
      if (i > 0 && blk_free[i - 1]) fold_next(i - 1);
      return ffa_pkg::ST_OK;
    endfunction

    // accepted input word: predict and queue its result
    function void note_word(logic cmd, logic [ffa_pkg::SZ_W-1:0] req,
                            logic [ffa_pkg::OFF_W-1:0] off,
                            output logic [ffa_pkg::OFF_W-1:0] grant,
                            output logic [ffa_pkg::ST_W-1:0] st);
      int unsigned g;
      g = 0;
      if (cmd == CMD_ALLOC) st = alloc_bytes(req, g);
      else st = free_block(off);
      grant = g[ffa_pkg::OFF_W-1:0];
      exp_offset_q.push_back(grant);
      exp_status_q.push_back(st);
    endfunction

    function void check_result(logic [ffa_pkg::OFF_W-1:0] grant,
                               logic [ffa_pkg::ST_W-1:0] st);
      logic [ffa_pkg::OFF_W-1:0] e_off;
      logic [ffa_pkg::ST_W-1:0]  e_st;
      if (exp_status_q.size() == 0) begin
        $error("result with nothing expected: offset %0d status %0d", grant, st);
        errors++;
        return;
      end
      e_off = exp_offset_q.pop_front();
      e_st  = exp_status_q.pop_front();
      n_results++;
      if (e_st <= ffa_pkg::ST_FULL) n_by_status[e_st]++;
      if (grant !== e_off) begin
        $error("granted_offset: expected %0d actual %0d", e_off, grant);
        errors++;
      end
      if (st !== e_st) begin
        $error("status: expected %0d actual %0d", e_st, st);
        errors++;
      end
    endfunction

    function int pending();
      return exp_status_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [ffa_pkg::SZ_W-1:0]  in_request_bytes = '0;
  logic [ffa_pkg::OFF_W-1:0] in_data_offset = '0;
  logic out_valid;
  logic [ffa_pkg::OFF_W-1:0] out_granted_offset;
  logic [ffa_pkg::ST_W-1:0]  out_status;

  heap_scoreboard sb = new();
  logic [ffa_pkg::OFF_W-1:0] live_q[$];   // offsets currently held by the stimulus
  int idle_pct;                  // chance per cycle that the sender idles
  int idle_cycles;
  int n_words;

  always #5 clk = ~clk;

  first_fit_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_data_offset(in_data_offset), .out_valid(out_valid),
    .out_granted_offset(out_granted_offset), .out_status(out_status)
  );

  // Monitor: sample both handshakes at the edge, before driven updates land.
  always @(posedge clk) begin
    logic [ffa_pkg::OFF_W-1:0] g;
    logic [ffa_pkg::ST_W-1:0]  s;
    logic seen;
    if (rst_n) begin
      seen = 1'b0;
      if (start && !busy) begin
        sb.note_word(in_command, in_request_bytes, in_data_offset, g, s);
        n_words++;
        // keep the live list in step with the predicted heap
        if (s == ffa_pkg::ST_OK) begin
          if (in_command == CMD_ALLOC) live_q.push_back(g);
          else begin
            foreach (live_q[j]) if (live_q[j] == in_data_offset) begin
              live_q.delete(j);
              break;
            end
          end
        end
        seen = 1'b1;
      end
      if (out_valid) begin
        sb.check_result(out_granted_offset, out_status);
        seen = 1'b1;
      end
      idle_cycles <= seen ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: no word accepted and no result for too long means a hang.
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a word or result", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one word. start stays high after acceptance so back-to-back words
  // never see start dropped and raised within one step.
  task automatic send_word(logic cmd, logic [ffa_pkg::SZ_W-1:0] req,
                           logic [ffa_pkg::OFF_W-1:0] off);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_request_bytes <= req;
    in_data_offset <= off;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every queued result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic alloc_word(int unsigned n);
    send_word(CMD_ALLOC, n[ffa_pkg::SZ_W-1:0], ffa_pkg::OFF_W'($urandom));
  endtask

  task automatic free_word(int unsigned off);
    send_word(CMD_FREE, ffa_pkg::SZ_W'($urandom), off[ffa_pkg::OFF_W-1:0]);
  endtask

  // Random word: mostly sane alloc/free traffic, a few junk words.
  task automatic random_word(int alloc_pct);
    int r;
    int unsigned sz;
    r = $urandom_range(99);
    if (r < 6) begin
      send_word(1'($urandom), ffa_pkg::SZ_W'($urandom), ffa_pkg::OFF_W'($urandom));
    end else if ($urandom_range(99) < alloc_pct || live_q.size() == 0) begin
      r = $urandom_range(99);
      if (r < 80) sz = $urandom_range(48, 1);
      else if (r < 95) sz = $urandom_range(600, 49);
      else if (r < 97) sz = 0;
      else sz = $urandom_range(8191, 2000);
      alloc_word(sz);
    end else begin
      r = $urandom_range(99);
      if (r < 88) free_word(live_q[$urandom_range(live_q.size() - 1)]);
      else if (r < 94) free_word(live_q[$urandom_range(live_q.size() - 1)] + 1); // mid-data
      else free_word($urandom_range(4095));
    end
  endtask

  initial begin
    idle_cycles = 0;
    n_words = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    idle_pct = 12;
    alloc_word(0);              // zero size
    alloc_word(4096);           // larger than the heap
    alloc_word(8191);           // all request bits set
    alloc_word(4080);           // exact fit of the whole heap
    alloc_word(1);              // nothing left
    free_word(16);
    free_word(16);              // double free
    free_word(0);               // header offset
    free_word(4095);            // top of the heap
    alloc_word(100);            // split
    alloc_word(200);
    alloc_word(4080 - 300 - 32);  // exact fit of the remainder
    free_word(16 + 116 + 4);    // inside a data area
    free_word(16 + 116);        // middle block, neighbors used
    free_word(16);              // merges with the next free block
    free_word(16 + 116 + 216);  // last block: merges with the previous free block
    free_word(16);              // already merged away
    alloc_word(4079);           // neither exact nor room for a header
    alloc_word(4063);           // just fits with a split
    free_word(16);
    drain();

    // Fill the table, then ask for a split and for an exact fit
    live_q.delete();
    for (int i = 0; i < 63; i++) alloc_word(1);
    alloc_word(2);              // table full
    alloc_word(4080 - 63 * 17); // exact fit of the last free block
    free_word(16 + 17 * 62);
    drain();
    while (live_q.size() > 0) free_word(live_q[0]);
    drain();

    // Random phases: sender idles 12%, then 81%, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 12 : (ph == 1) ? 81 : 0;
      for (int i = 0; i < 520; i++) begin
        random_word(((i / 40) % 2 == 0) ? 75 : 30);
        if (i == 300) drain();
      end
    end

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d words, %0d results: ok %0d zero %0d nospace %0d",
             n_words, sb.n_results, sb.n_by_status[ffa_pkg::ST_OK],
             sb.n_by_status[ffa_pkg::ST_ZERO], sb.n_by_status[ffa_pkg::ST_NOSPACE]);
    $display("badptr %0d full %0d; sender idled at 12%%, 81%% and 0%%; %0d mismatches",
             sb.n_by_status[ffa_pkg::ST_BADPTR], sb.n_by_status[ffa_pkg::ST_FULL],
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
